[rtl/sha_pkg.sv]
// shared types, constants and round functions for the sha-256 stream hasher
`default_nettype none
package sha_pkg;

  // control sequence of the hasher
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_OUT
  } state_t;

  localparam int unsigned WORDS       = 8;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS      = 64;
  localparam logic [7:0]  PAD_MARK    = 8'h80;
  localparam logic [5:0]  LEN_OFFSET  = 6'd56;
  localparam logic [5:0]  LAST_BYTE   = 6'd63;

  // standard initial hash value
  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] v;
    case (i)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  // round constants
  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage
`default_nettype wire

[rtl/sha_ram.sv]
// generic single-port-write ram with registered read
`default_nettype none
module sha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[rtl/sha256_stream_hasher.sv]
// top level of the sha-256 stream hasher
//
// channel  | signals                                        | direction
// input    | in_valid/in_ready, data_byte, has_byte,         | in
//          | end_of_message                                  |
// output   | out_valid/out_ready, digest_word, word_index,   | out
//          | last_word                                       |
//
// one beat per cycle while bytes only fill the block buffer (16 x 32 ram).
// each full block stalls the input for compression: one round a cycle through a
// single round unit, with the first 16 schedule words read from the ram.
// end of message adds the padding bytes plus one or two compressions,
// then eight output beats; the input is held off until the last one is taken.
// synchronous reset loads the initial hash value and clears all counters.
`default_nettype none
module sha256_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        has_byte,
  input  wire logic        end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  sha_pkg::state_t state, state_next, comp_ret;

  logic [5:0]  fill;
  logic [63:0] bits;
  logic [63:0] len;
  logic [23:0] acc;
  logic        mark_sent;
  logic        len_ok;
  logic [6:0]  rnd;
  logic [31:0] r [8];
  logic [31:0] w_win [16];
  logic [31:0] h [8];
  logic [2:0]  idx;

  logic        push_en;
  logic [7:0]  push_byte;
  logic        block_full;
  logic        finishing;
  logic        in_acc;
  logic        out_acc;
  logic [31:0] rd_data;
  logic [5:0]  t;
  logic [31:0] w_new, w_t, t1, t2;

  // block buffer as packed words
  sha_ram #(.WIDTH(32), .DEPTH(sha_pkg::BLOCK_WORDS)) u_buf (
    .clk     (clk),
    .wr_en   (push_en && (fill[1:0] == 2'd3)),
    .wr_addr (fill[5:2]),
    .wr_data ({acc, push_byte}),
    .rd_addr (rnd[3:0]),
    .rd_data (rd_data)
  );

  // handshakes
  assign in_ready  = (state == sha_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (state == sha_pkg::ST_OUT);
  assign out_acc   = out_valid && out_ready;

  assign digest_word = h[idx];
  assign word_index  = idx;
  assign last_word   = (idx == 3'd7);

  // byte source: input or padding
  always_comb begin
    push_en   = 1'b0;
    push_byte = data_byte;
    if (state == sha_pkg::ST_IDLE) begin
      push_en = in_acc && has_byte;
    end else if (state == sha_pkg::ST_PAD) begin
      push_en = 1'b1;
      if (!mark_sent) begin
        push_byte = sha_pkg::PAD_MARK;
      end else if (len_ok && (fill >= sha_pkg::LEN_OFFSET)) begin
        push_byte = len[(3'd7 - fill[2:0]) * 8 +: 8];
      end else begin
        push_byte = 8'h00;
      end
    end
  end

  assign block_full = push_en && (fill == sha_pkg::LAST_BYTE);
  assign finishing  = (state == sha_pkg::ST_PAD) && mark_sent && len_ok &&
                      (fill == sha_pkg::LAST_BYTE);

  // message schedule and round datapath
  assign t     = 6'(rnd - 7'd1);
  assign w_new = w_win[0] + sha_pkg::sig0(w_win[1]) + w_win[9] + sha_pkg::sig1(w_win[14]);
  assign w_t   = (t < 6'd16) ? rd_data : w_new;
  assign t1    = r[7] + sha_pkg::bsig1(r[4]) + ((r[4] & r[5]) ^ (~r[4] & r[6])) +
                 sha_pkg::round_k(t) + w_t;
  assign t2    = sha_pkg::bsig0(r[0]) + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sha_pkg::ST_IDLE: begin
        if (block_full) begin
          state_next = sha_pkg::ST_COMP;
        end else if (in_acc && end_of_message) begin
          state_next = sha_pkg::ST_PAD;
        end
      end
      sha_pkg::ST_PAD: begin
        if (block_full) begin
          state_next = sha_pkg::ST_COMP;
        end
      end
      sha_pkg::ST_COMP: begin
        if (rnd == 7'd65) begin
          state_next = comp_ret;
        end
      end
      sha_pkg::ST_OUT: begin
        if (out_acc && last_word) begin
          state_next = sha_pkg::ST_IDLE;
        end
      end
      default: state_next = sha_pkg::ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      bits      <= '0;
      mark_sent <= 1'b0;
      len_ok    <= 1'b0;
      rnd       <= '0;
      idx       <= '0;
      comp_ret  <= sha_pkg::ST_IDLE;
      for (int i = 0; i < 8; i++) begin
        h[i] <= sha_pkg::init_hash(3'(i));
      end
    end else begin
      // byte packing
      if (push_en) begin
        fill <= 6'(fill + 6'd1);
        acc  <= {acc[15:0], push_byte};
      end
      // input beat
      if (in_acc) begin
        if (end_of_message) begin
          len       <= bits + (has_byte ? 64'd8 : 64'd0);
          bits      <= '0;
          mark_sent <= 1'b0;
          len_ok    <= 1'b0;
        end else if (has_byte) begin
          bits <= bits + 64'd8;
        end
        comp_ret <= end_of_message ? sha_pkg::ST_PAD : sha_pkg::ST_IDLE;
      end
      // padding progress
      if (state == sha_pkg::ST_PAD) begin
        mark_sent <= 1'b1;
        if (!mark_sent && (fill < sha_pkg::LEN_OFFSET)) begin
          len_ok <= 1'b1;
        end
        if (block_full) begin
          len_ok   <= 1'b1;
          comp_ret <= finishing ? sha_pkg::ST_OUT : sha_pkg::ST_PAD;
        end
      end
      // compression rounds
      if (state == sha_pkg::ST_COMP) begin
        if (rnd == 7'd0) begin
          for (int i = 0; i < 8; i++) begin
            r[i] <= h[i];
          end
        end else if (rnd <= 7'd64) begin
          r[0] <= t1 + t2;
          r[1] <= r[0];
          r[2] <= r[1];
          r[3] <= r[2];
          r[4] <= r[3] + t1;
          r[5] <= r[4];
          r[6] <= r[5];
          r[7] <= r[6];
          for (int i = 0; i < 15; i++) begin
            w_win[i] <= w_win[i + 1];
          end
          w_win[15] <= w_t;
        end else begin
          for (int i = 0; i < 8; i++) begin
            h[i] <= h[i] + r[i];
          end
        end
        rnd <= (rnd == 7'd65) ? 7'd0 : 7'(rnd + 7'd1);
        idx <= '0;
      end
      // digest output
      if (out_acc) begin
        idx <= 3'(idx + 3'd1);
        if (last_word) begin
          for (int i = 0; i < 8; i++) begin
            h[i] <= sha_pkg::init_hash(3'(i));
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/sha_checker.sv]
// port-level checks for the sha-256 stream hasher
`default_nettype none
module sha_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] digest_word,
  input wire logic [2:0]  word_index,
  input wire logic        last_word
);

  // last flag marks word seven only
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word does not match word_index");

  // input is held off while the digest is shown
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready during digest output");

  // stalled digest beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(digest_word) && $stable(word_index)))
    else $error("stalled digest beat changed");

  // words advance in order and stop after the last
  a_next: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_word) |=> (word_index == $past(word_index) + 3'd1))
    else $error("digest words out of order");

  a_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_word) |=> !out_valid)
    else $error("output continues after last word");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .digest_word (digest_word),
  .word_index  (word_index),
  .last_word   (last_word)
);
`default_nettype wire

[sim/tb_sha256_stream_hasher.sv]
// testbench for the sha-256 stream hasher: directed and random messages checked against a local digest model
`timescale 1ns / 1ps
`default_nettype none
module tb_sha256_stream_hasher;

  // item offered on the input channel
  typedef struct {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } msg_item_t;

  // one digest word expected on the output channel
  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        has_byte = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  msg_item_t    pending_items[$];
  digest_beat_t expected_words[$];
  int           error_count = 0;
  int           send_gap = 0;
  int           recv_gap = 0;
  int           hold_off = 0;
  int           accepted_beats = 0;
  bit           long_hold_done = 1'b0;
  bit           in_fire = 1'b0;

  // local hash state
  logic [31:0] hash_state[8];
  logic [7:0]  hash_block[64];
  logic [5:0]  hash_fill;
  logic [63:0] hash_bits;

  sha256_stream_hasher u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .has_byte(has_byte), .end_of_message(end_of_message),
    .out_valid(out_valid), .out_ready(out_ready),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] initial_word(input int i);
    logic [31:0] iv[8];
    iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
           32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return iv[i];
  endfunction

  // one 64-round compression of hash_block into hash_state
  task automatic compress_block();
    logic [31:0] kt[64];
    logic [31:0] w[64];
    logic [31:0] r[8];
    logic [31:0] t1, t2, x, y;
    kt = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    for (int t = 0; t < 16; t++)
      w[t] = {hash_block[4*t], hash_block[4*t+1], hash_block[4*t+2], hash_block[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      x = w[t-15];
      y = w[t-2];
      w[t] = w[t-16] + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + w[t-7]
           + (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10));
    end
    for (int i = 0; i < 8; i++) r[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25))
         + ((r[4] & r[5]) ^ (~r[4] & r[6])) + kt[t] + w[t];
      t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22))
         + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
      r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + r[i];
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    hash_block[hash_fill] = b;
    hash_fill = hash_fill + 6'd1;
    if (hash_fill == 6'd0) compress_block();
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = initial_word(i);
    hash_fill = '0;
    hash_bits = '0;
  endtask

  // absorb one accepted beat; on end of message pad and queue the digest
  task automatic hash_beat(input msg_item_t it);
    logic [63:0] len;
    digest_beat_t d;
    if (it.has_byte) begin
      absorb_byte(it.data_byte);
      hash_bits = hash_bits + 64'd8;
    end
    if (it.end_of_message) begin
      len = hash_bits;
      absorb_byte(8'h80);
      while (hash_fill != 6'd56) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(len[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        d.digest_word = hash_state[i];
        d.word_index  = i[2:0];
        d.last_word   = (i == 7);
        expected_words.push_back(d);
      end
      restart_hash();
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  task automatic add_item(input logic [7:0] b, input logic hb, input logic eom);
    msg_item_t it;
    it.data_byte = b;
    it.has_byte = hb;
    it.end_of_message = eom;
    pending_items.push_back(it);
  endtask

  // a message of n bytes with random content, optionally ending on a bare end item
  task automatic add_message(input int n, input bit bare_end);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) add_item(8'($urandom), 1'b0, 1'b0);
      add_item(8'($urandom), 1'b1, (i == n - 1) && !bare_end);
    end
    if (bare_end || n == 0) add_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // driver: present pending items with random gaps
  always @(negedge clk) begin
    if (!rst) begin
      if (in_fire) begin
        if (send_gap == 0 && pending_items.size() > 1) begin
          void'(pending_items.pop_front());
          data_byte      <= pending_items[0].data_byte;
          has_byte       <= pending_items[0].has_byte;
          end_of_message <= pending_items[0].end_of_message;
          send_gap       <= pick_gap();
        end else begin
          void'(pending_items.pop_front());
          in_valid <= 1'b0;
        end
      end else if (!in_valid && pending_items.size() > 0) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else begin
          in_valid       <= 1'b1;
          data_byte      <= pending_items[0].data_byte;
          has_byte       <= pending_items[0].has_byte;
          end_of_message <= pending_items[0].end_of_message;
          send_gap       <= pick_gap();
        end
      end else if (in_valid && send_gap > 0 && !in_ready) begin
        send_gap <= send_gap;
      end
    end
  end

  // receiver readiness, with one long hold-off after the fortieth accepted digest beat
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_off > 0) begin
        hold_off  <= hold_off - 1;
        out_ready <= 1'b0;
      end else if (accepted_beats == 40 && !long_hold_done) begin
        hold_off       <= 600;
        long_hold_done <= 1'b1;
        out_ready      <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap  <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready) recv_gap <= pick_gap();
      end
    end
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk) begin
    digest_beat_t e;
    in_fire <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) hash_beat(pending_items[0]);
      if (out_valid && out_ready) begin
        accepted_beats <= accepted_beats + 1;
        if (expected_words.size() == 0) begin
          $error("digest beat with nothing expected: word %h", digest_word);
          error_count++;
        end else begin
          e = expected_words.pop_front();
          if (digest_word !== e.digest_word) begin
            $error("digest_word expected %h actual %h", e.digest_word, digest_word);
            error_count++;
          end
          if (word_index !== e.word_index) begin
            $error("word_index expected %0d actual %0d", e.word_index, word_index);
            error_count++;
          end
          if (last_word !== e.last_word) begin
            $error("last_word expected %0d actual %0d", e.last_word, last_word);
            error_count++;
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    int lens[3];
    restart_hash();
    // directed: empty message, byte extremes, boundaries of the padding
    add_item(8'hff, 1'b0, 1'b1);
    add_item(8'h00, 1'b1, 1'b1);
    add_item(8'hff, 1'b1, 1'b0);
    add_item(8'h5a, 1'b0, 1'b0);
    add_item(8'ha5, 1'b1, 1'b1);
    add_message(3, 1'b1);
    add_message(5, 1'b0);
    lens = '{56, 63, 64};
    foreach (lens[i]) add_message(lens[i], $urandom_range(0, 1) == 1);
    // random messages, mostly short
    while (pending_items.size() < 245) begin
      if ($urandom_range(0, 5) == 0) begin
        add_message($urandom_range(20, 40), $urandom_range(0, 1) == 1);
      end else begin
        add_message($urandom_range(0, 20), $urandom_range(0, 3) == 0);
      end
    end
    add_item(8'($urandom), 1'b1, 1'b1);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait (pending_items.size() == 0);
    wait (expected_words.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire

[sha256_stream_hasher.f]
rtl/sha_pkg.sv
rtl/sha_ram.sv
rtl/sha256_stream_hasher.sv
rtl/sha_checker.sv
sim/tb_sha256_stream_hasher.sv
